>>> sv/bcs_pkg.sv
// shared constants and types for the bezier curve sampler
`timescale 1ns / 1ps
package bcs_pkg;

    localparam int DEF_MAX_CONTROL_POINTS = 32;
    localparam int DEF_COORD_WIDTH        = 16;
    localparam int DEF_PARAM_FRAC_BITS    = 16;

    localparam int          NS_W        = 7;
    localparam int          SAMPLES_MAX = 64;
    localparam logic [6:0]  NS_RESET    = 7'd16;
    localparam int          IDX_W       = 6;

    typedef struct packed {
        logic             bank;
        logic [IDX_W-1:0] last_idx;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [IDX_W-1:0] addr;
    } wr_ctl_t;

endpackage

>>> sv/bcs_front.sv
// input side: addresses control point writes and issues one job per curve
`timescale 1ns / 1ps
module bcs_front #(
    parameter int MAX_CONTROL_POINTS = bcs_pkg::DEF_MAX_CONTROL_POINTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_tlast,
    input  bcs_pkg::q_status_t q_stat,
    output logic               push,
    output bcs_pkg::job_t      push_job,
    output bcs_pkg::wr_ctl_t   wr
);

    localparam logic [bcs_pkg::IDX_W-1:0] MAXC = bcs_pkg::IDX_W'(MAX_CONTROL_POINTS);

    logic [bcs_pkg::IDX_W-1:0] count_reg, count_next;
    logic                      bank_reg, bank_next;
    logic                      accept, room;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign room     = count_reg < MAXC;
    assign push     = accept && s_tlast;

    assign wr.en   = accept && room;
    assign wr.bank = bank_reg;
    assign wr.addr = count_reg;

    assign push_job.bank     = bank_reg;
    assign push_job.last_idx = room ? count_reg : count_reg - 1'b1;

    always_comb
    begin
        count_next = count_reg;
        bank_next  = bank_reg;
        if (accept && room)
        begin
            count_next = count_reg + 1'b1;
        end
        if (push)
        begin
            count_next = '0;
            bank_next  = !bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

>>> sv/bcs_queue.sv
// two-entry job queue between front and back
`timescale 1ns / 1ps
module bcs_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bcs_pkg::job_t      push_job,
    input  logic               pop,
    output bcs_pkg::job_t      head,
    output bcs_pkg::q_status_t q_stat
);

    bcs_pkg::job_t ent_reg [0:1];
    logic [1:0]    cnt_reg, cnt_next;
    logic          hd_reg, hd_next;

    assign head         = ent_reg[hd_reg];
    assign q_stat.full  = cnt_reg == 2'd2;
    assign q_stat.empty = cnt_reg == 2'd0;

    always_comb
    begin
        cnt_next = cnt_reg;
        hd_next  = hd_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
        if (pop)
        begin
            hd_next = !hd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[hd_reg ^ cnt_reg[0]] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            hd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            hd_reg  <= hd_next;
        end
    end

endmodule

>>> sv/bcs_back.sv
// evaluation side: point store, step divider, bernstein weights, weighted sum and result register
`timescale 1ns / 1ps
module bcs_back #(
    parameter int MAX_CONTROL_POINTS = bcs_pkg::DEF_MAX_CONTROL_POINTS,
    parameter int COORD_WIDTH        = bcs_pkg::DEF_COORD_WIDTH,
    parameter int PARAM_FRAC_BITS    = bcs_pkg::DEF_PARAM_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bcs_pkg::NS_W-1:0]      num_samples,
    input  bcs_pkg::wr_ctl_t              wr,
    input  logic signed [COORD_WIDTH-1:0] wr_x,
    input  logic signed [COORD_WIDTH-1:0] wr_y,
    input  bcs_pkg::q_status_t            q_stat,
    input  bcs_pkg::job_t                 head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic                          out_last
);

    localparam int L    = MAX_CONTROL_POINTS + 1;
    localparam int AW   = (MAX_CONTROL_POINTS > 1) ? $clog2(MAX_CONTROL_POINTS) : 1;
    localparam int DEP  = 2 * (2 ** AW);
    localparam int WW   = PARAM_FRAC_BITS + 1;
    localparam int ACCW = PARAM_FRAC_BITS + COORD_WIDTH + 8;
    localparam int SW   = $clog2(L);
    localparam int DCW  = $clog2(PARAM_FRAC_BITS + 1);
    localparam int IW   = bcs_pkg::IDX_W;

    localparam logic [WW-1:0]     T_ONE   = WW'(1) << PARAM_FRAC_BITS;
    localparam logic [2*WW:0]     W_HALF  = (2*WW+1)'(1) << (PARAM_FRAC_BITS - 1);
    localparam logic signed [ACCW-1:0] A_HALF = ACCW'(1) << (PARAM_FRAC_BITS - 1);
    localparam logic [SW-1:0]     STEP_LAST = SW'(L - 1);
    localparam logic [DCW-1:0]    DC_TOP  = DCW'(PARAM_FRAC_BITS);
    localparam logic signed [ACCW-1:0] SAT_HI = ACCW'((2 ** (COORD_WIDTH - 1)) - 1);
    localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - ACCW'(1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_INIT  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_PRIME = 3'd4;
    localparam logic [2:0] ST_ACC   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;
    localparam logic [2:0] ST_WAIT  = 3'd7;

    logic signed [COORD_WIDTH-1:0] mem_x [0:DEP-1];
    logic signed [COORD_WIDTH-1:0] mem_y [0:DEP-1];
    logic signed [COORD_WIDTH-1:0] rdx_reg, rdy_reg;
    logic [AW:0]                   rd_addr;
    logic [IW-1:0]                 rd_idx;

    logic [2:0]     state_reg;
    logic [IW-1:0]  n_reg, rnd_reg, j_reg, k_reg, d_reg;
    logic           bank_reg;
    logic [WW-1:0]  qd_reg, t_reg;
    logic [6:0]     rd_reg, tr_reg;
    logic [DCW-1:0] dcnt_reg;
    logic [SW-1:0]  step_reg;
    logic [WW-1:0]  w_reg [0:L-1];
    logic [WW-1:0]  prev_reg;
    logic signed [ACCW-1:0] accx_reg, accy_reg;
    logic signed [COORD_WIDTH-1:0] ox_reg, oy_reg;
    logic           olast_reg, valid_reg;

    logic [bcs_pkg::NS_W-1:0] s_eff;
    logic [WW-1:0]   u;
    logic [2*WW:0]   wsum;
    logic [WW-1:0]   neww;
    logic [6:0]      remsh;
    logic            ge;
    logic [7:0]      tsum;
    logic signed [ACCW-1:0] px, py;

    function automatic logic signed [COORD_WIDTH-1:0] rsat(input logic signed [ACCW-1:0] a);
        logic signed [ACCW-1:0] v;
        v = (a + A_HALF) >>> PARAM_FRAC_BITS;
        if (v > SAT_HI)
        begin
            v = SAT_HI;
        end
        if (v < SAT_LO)
        begin
            v = SAT_LO;
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    always_comb
    begin
        if (num_samples == '0)
        begin
            s_eff = bcs_pkg::NS_W'(1);
        end
        else if (num_samples > bcs_pkg::NS_W'(bcs_pkg::SAMPLES_MAX))
        begin
            s_eff = bcs_pkg::NS_W'(bcs_pkg::SAMPLES_MAX);
        end
        else
        begin
            s_eff = num_samples;
        end
    end

    assign u     = T_ONE - t_reg;
    assign wsum  = (2*WW+1)'(u * w_reg[0]) + (2*WW+1)'(t_reg * prev_reg) + W_HALF;
    assign neww  = wsum[PARAM_FRAC_BITS +: WW];
    assign remsh = {rd_reg[5:0], dcnt_reg == DC_TOP};
    assign ge    = remsh >= {1'b0, d_reg};
    assign tsum  = {1'b0, tr_reg} + {1'b0, rd_reg};
    assign px    = ACCW'($signed({1'b0, w_reg[0]}) * rdx_reg);
    assign py    = ACCW'($signed({1'b0, w_reg[0]}) * rdy_reg);

    assign rd_idx  = (state_reg == ST_PRIME) ? '0 : j_reg + 1'b1;
    assign rd_addr = {bank_reg, rd_idx[AW-1:0]};

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_x[{wr.bank, wr.addr[AW-1:0]}] <= wr_x;
            mem_y[{wr.bank, wr.addr[AW-1:0]}] <= wr_y;
        end
        rdx_reg <= mem_x[rd_addr];
        rdy_reg <= mem_y[rd_addr];
    end

    assign pop      = (state_reg == ST_WAIT) && m_tready && (k_reg == d_reg);
    assign m_tvalid = valid_reg;
    assign out_x    = ox_reg;
    assign out_y    = oy_reg;
    assign out_last = olast_reg;

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                n_reg    <= head.last_idx;
                bank_reg <= head.bank;
                d_reg    <= IW'(s_eff - 1'b1);
                k_reg    <= '0;
                t_reg    <= '0;
                tr_reg   <= '0;
                rd_reg   <= '0;
                qd_reg   <= '0;
                dcnt_reg <= DC_TOP;
            end
            ST_DIV:
            begin
                rd_reg   <= ge ? remsh - {1'b0, d_reg} : remsh;
                qd_reg   <= {qd_reg[WW-2:0], ge};
                dcnt_reg <= dcnt_reg - 1'b1;
                tr_reg   <= {2'b0, d_reg[5:1]};
            end
            ST_INIT:
            begin
                w_reg[0] <= T_ONE;
                for (int i = 1; i < L; i++)
                begin
                    w_reg[i] <= '0;
                end
                prev_reg <= '0;
                step_reg <= '0;
                rnd_reg  <= '0;
            end
            ST_ROUND:
            begin
                for (int i = 0; i < L - 1; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[L-1] <= neww;
                if (step_reg == STEP_LAST)
                begin
                    step_reg <= '0;
                    prev_reg <= '0;
                    rnd_reg  <= rnd_reg + 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                    prev_reg <= w_reg[0];
                end
            end
            ST_PRIME:
            begin
                accx_reg <= '0;
                accy_reg <= '0;
                j_reg    <= '0;
            end
            ST_ACC:
            begin
                accx_reg <= accx_reg + px;
                accy_reg <= accy_reg + py;
                j_reg    <= j_reg + 1'b1;
                for (int i = 0; i < L - 1; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[L-1] <= w_reg[0];
            end
            ST_FIN:
            begin
                ox_reg    <= rsat(accx_reg);
                oy_reg    <= rsat(accy_reg);
                olast_reg <= k_reg == d_reg;
            end
            ST_WAIT:
            begin
                if (m_tready && (k_reg != d_reg))
                begin
                    k_reg <= k_reg + 1'b1;
                    if (tsum >= {2'b0, d_reg})
                    begin
                        tr_reg <= 7'(tsum - {2'b0, d_reg});
                        t_reg  <= t_reg + qd_reg + 1'b1;
                    end
                    else
                    begin
                        tr_reg <= tsum[6:0];
                        t_reg  <= t_reg + qd_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        state_reg <= (s_eff == bcs_pkg::NS_W'(1)) ? ST_INIT : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (dcnt_reg == '0)
                    begin
                        state_reg <= ST_INIT;
                    end
                end
                ST_INIT:
                begin
                    state_reg <= (n_reg == '0) ? ST_PRIME : ST_ROUND;
                end
                ST_ROUND:
                begin
                    if (step_reg == STEP_LAST && rnd_reg == n_reg - 1'b1)
                    begin
                        state_reg <= ST_PRIME;
                    end
                end
                ST_PRIME:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (j_reg == n_reg)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    valid_reg <= 1'b1;
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (m_tready)
                    begin
                        valid_reg <= 1'b0;
                        state_reg <= (k_reg == d_reg) ? ST_IDLE : ST_INIT;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/bezier_curve_sampler_core.sv
// top level of the bezier curve sampler
// a final item starts evaluation: per curve with S > 1 a divider forms the parameter
// step, then each of the S samples builds its weights on the rotating weight line
// and forms the weighted sum over the points;
// one curve is buffered while the next one loads
// reset: asynchronous active low, count and queue cleared, num_samples = 16
`timescale 1ns / 1ps
module bezier_curve_sampler_core #(
    parameter int MAX_CONTROL_POINTS = bcs_pkg::DEF_MAX_CONTROL_POINTS,
    parameter int COORD_WIDTH        = bcs_pkg::DEF_COORD_WIDTH,
    parameter int PARAM_FRAC_BITS    = bcs_pkg::DEF_PARAM_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,  // point_x, point_y
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,  // curve_x, curve_y
    output logic                             m_tlast,
    input  logic                             num_samples_we,
    input  logic [bcs_pkg::NS_W-1:0]         num_samples_wdata
);

    localparam int DW = ((2*COORD_WIDTH+7)/8)*8;

    logic [bcs_pkg::NS_W-1:0] ns_reg;
    bcs_pkg::q_status_t       q_stat;
    bcs_pkg::job_t            push_job, head;
    bcs_pkg::wr_ctl_t         wr;
    logic                     push, pop;
    logic signed [COORD_WIDTH-1:0] ox, oy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_reg <= bcs_pkg::NS_RESET;
        end
        else if (num_samples_we)
        begin
            ns_reg <= num_samples_wdata;
        end
    end

    bcs_front #(
        .MAX_CONTROL_POINTS(MAX_CONTROL_POINTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job),
        .wr       (wr)
    );

    bcs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    bcs_back #(
        .MAX_CONTROL_POINTS(MAX_CONTROL_POINTS),
        .COORD_WIDTH       (COORD_WIDTH),
        .PARAM_FRAC_BITS   (PARAM_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .num_samples (ns_reg),
        .wr          (wr),
        .wr_x        (s_tdata[COORD_WIDTH-1:0]),
        .wr_y        (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .q_stat      (q_stat),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_x       (ox),
        .out_y       (oy),
        .out_last    (m_tlast)
    );

    assign m_tdata = DW'({oy, ox});

    a_job_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !q_stat.empty)
        else $error("final item left no job");

    a_out_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !q_stat.empty)
        else $error("result without pending job");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (m_tvalid && m_tready && m_tlast))
        else $error("job retired before last sample");

endmodule

>>> sim/tb.sv
// testbench for the bezier curve sampler core
`timescale 1ns / 1ps
module tb;

    localparam int NPTS = 32;
    localparam longint ONE = 64'd65536;
    localparam longint HALF = 64'd32768;
    localparam int WD_LIMIT = 20000;

    class curve_scoreboard;
        shortint px[NPTS];
        shortint py[NPTS];
        int cnt;
        int nsamp;
        logic [32:0] pending[$];
        int errors;

        function new();
            cnt = 0;
            nsamp = bcs_pkg::NS_RESET;
            errors = 0;
        endfunction

        function void set_samples(int v);
            nsamp = v & 7'h7f;
        endfunction

        function shortint round_sat(longint acc);
            longint v;
            longint q;
            v = acc + HALF;
            q = v >>> 16;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return shortint'(q);
        endfunction

        function void note_point(shortint x, shortint y, bit last);
            longint w[NPTS+1];
            longint t, u, sm, ax, ay;
            int s, n;
            if (cnt < NPTS)
            begin
                px[cnt] = x;
                py[cnt] = y;
                cnt++;
            end
            if (!last) return;
            s = nsamp;
            if (s < 1) s = 1;
            if (s > bcs_pkg::SAMPLES_MAX) s = bcs_pkg::SAMPLES_MAX;
            n = cnt - 1;
            for (int k = 0; k < s; k++)
            begin
                t = (s == 1) ? 0 : (k * ONE + (s - 1) / 2) / (s - 1);
                u = ONE - t;
                w[0] = ONE;
                for (int r = 1; r <= n; r++)
                begin
                    w[r] = 0;
                    for (int i = r; i >= 0; i--)
                    begin
                        sm = u * w[i];
                        if (i > 0) sm += t * w[i-1];
                        w[i] = (sm + HALF) >> 16;
                    end
                end
                ax = 0;
                ay = 0;
                for (int i = 0; i <= n; i++)
                begin
                    ax += w[i] * px[i];
                    ay += w[i] * py[i];
                end
                pending.insert(pending.size(), {k == s - 1, round_sat(ay), round_sat(ax)});
            end
            cnt = 0;
        endfunction

        function void check_sample(logic [31:0] d, logic l);
            logic [32:0] e;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected sample: expected none, actual %h last %b", $time, d, l);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e[15:0] !== d[15:0])
            begin
                $display("%0t curve_x: expected %h, actual %h", $time, e[15:0], d[15:0]);
                errors++;
            end
            if (e[31:16] !== d[31:16])
            begin
                $display("%0t curve_y: expected %h, actual %h", $time, e[31:16], d[31:16]);
                errors++;
            end
            if (e[32] !== l)
            begin
                $display("%0t final_sample: expected %b, actual %b", $time, e[32], l);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic s_tvalid, s_tready, s_tlast;
    logic [31:0] s_tdata;
    logic m_tvalid, m_tready, m_tlast;
    logic [31:0] m_tdata;
    logic ns_we;
    logic [6:0] ns_wdata;

    curve_scoreboard sb;
    bit calm;
    bit hold_off;
    int idle_cycles;

    bezier_curve_sampler_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .num_samples_we(ns_we), .num_samples_wdata(ns_wdata)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // receiver with random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready) sb.check_sample(m_tdata, m_tlast);
        if (hold_off) m_tready <= 1'b0;
        else m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task send_point(shortint x, shortint y, bit last);
        while (!calm && $urandom_range(99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_point(x, y, last);
    endtask

    task idle_in();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task write_samples(int v);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        ns_we <= 1'b1;
        ns_wdata <= 7'(v);
        @(posedge clk);
        ns_we <= 1'b0;
        sb.set_samples(v);
    endtask

    task random_curve(int npts);
        shortint x, y;
        for (int i = 0; i < npts; i++)
        begin
            x = shortint'($urandom);
            y = shortint'($urandom);
            if ($urandom_range(3) == 0) x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            send_point(x, y, i == npts - 1);
        end
        idle_in();
    endtask

    initial
    begin
        int sent;
        int npts;
        sb = new();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        m_tready = 0;
        ns_we = 0;
        ns_wdata = 0;
        calm = 0;
        hold_off = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, single point, reset sample count
        send_point(16'sh7fff, 16'sh8000, 1);
        send_point(16'sh8000, 16'sh7fff, 0);
        send_point(16'sh7fff, 16'sh8000, 0);
        send_point(16'sh8000, 16'sh7fff, 1);
        write_samples(1);
        send_point(16'sh1234, -16'sh0567, 0);
        send_point(16'sh7fff, 16'sh7fff, 1);
        write_samples(64);
        send_point(16'sh8000, 16'sh8000, 0);
        send_point(16'sh8000, 16'sh8000, 0);
        send_point(16'sh8000, 16'sh8000, 1);
        idle_in();
        write_samples(0);
        send_point(16'sh0010, 16'sh0020, 1);
        write_samples(127);
        send_point(16'sh0000, 16'sh0000, 0);
        send_point(16'shffff, 16'shffff, 1);
        write_samples(2);
        // overflow of the store, points beyond the 32nd discarded
        random_curve(34);
        sent = 46;

        write_samples(5);
        // long hold-off on the receiver while curves keep coming
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
            begin
                random_curve(3);
                random_curve(4);
                random_curve(2);
            end
        join
        sent += 9;

        // stretch with no random stalls on either side
        calm = 1;
        random_curve(6);
        random_curve(5);
        calm = 0;
        sent += 11;

        while (sent < 150)
        begin
            if ($urandom_range(5) == 0)
            begin
                calm = $urandom_range(3) == 0;
                write_samples($urandom_range(4) == 0 ? $urandom_range(64) : $urandom_range(8) + 1);
            end
            npts = ($urandom_range(9) == 0) ? $urandom_range(32, 20) : $urandom_range(6, 1);
            random_curve(npts);
            sent += npts;
        end
        s_tvalid <= 1'b0;
        calm = 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
